[hw/rtl/aup_pkg.sv]
package aup_pkg;

    localparam int CHAN_W         = 8;
    localparam int NUM_CHAN       = 3;
    localparam int PIXEL_W        = 32;
    localparam int NUM_W          = 2 * CHAN_W;
    localparam int BIT_IDX_W      = $clog2(CHAN_W);
    localparam int BITS_PER_STAGE = 2;
    localparam int NUM_DIV_STAGES = CHAN_W / BITS_PER_STAGE;
    localparam int STAGE_IDX_W    = $clog2(NUM_DIV_STAGES);
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

    // Lane order inside a word: 2 = red, 1 = green, 0 = blue.
    localparam int LANE_RED   = 2;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 0;

    typedef logic [CHAN_W-1:0] t_chan;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        t_chan            quo;
    } t_lane;

    typedef struct packed {
        t_lane [NUM_CHAN-1:0] lane;
        logic  [NUM_CHAN-1:0] sat;
        logic                 zero;
        t_chan                alpha;
        logic                 last;
    } t_work;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
        t_chan alpha;
        logic  last;
    } t_result;

endpackage

[hw/rtl/aup_in_if.sv]
interface aup_in_if;
    import aup_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] argb_pixel;
    logic               last_pixel;

    modport source (output valid, output argb_pixel, output last_pixel, input ready);
    modport sink   (input valid, input argb_pixel, input last_pixel, output ready);
endinterface

[hw/rtl/aup_out_if.sv]
interface aup_out_if;
    import aup_pkg::*;

    logic  valid;
    logic  ready;
    t_chan red_out;
    t_chan green_out;
    t_chan blue_out;
    t_chan alpha_out;
    logic  last_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output alpha_out, output last_out, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input alpha_out, input last_out, output ready);
endinterface

[hw/rtl/aup_prep.sv]
module aup_prep (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [aup_pkg::PIXEL_W-1:0]  i_argb_pixel,
    input  logic                         i_last_pixel,
    output logic                         o_valid,
    input  logic                         i_ready,
    output aup_pkg::t_work               o_work
);
    import aup_pkg::*;

    logic  r_valid;
    t_work r_work;
    t_work n_work;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_work  = r_work;

    // Form c*255 + alpha/2 per lane and flag quotients above the byte range.
    always_comb begin
        logic [NUM_W-1:0] c_ext;
        logic [NUM_W-1:0] a_ext;
        logic [NUM_W-1:0] num;
        a_ext        = NUM_W'(i_argb_pixel[PIXEL_W-1 -: CHAN_W]);
        n_work       = '0;
        n_work.alpha = i_argb_pixel[PIXEL_W-1 -: CHAN_W];
        n_work.zero  = (n_work.alpha == '0);
        n_work.last  = i_last_pixel;
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            c_ext = NUM_W'(i_argb_pixel[ch*CHAN_W +: CHAN_W]);
            num   = (c_ext << CHAN_W) - c_ext + (a_ext >> 1);
            n_work.lane[ch].rem = num;
            n_work.lane[ch].quo = '0;
            n_work.sat[ch]      = (num >= (a_ext << CHAN_W));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

endmodule

[hw/rtl/aup_div_stage.sv]
module aup_div_stage (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [aup_pkg::STAGE_IDX_W-1:0]   i_stage,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  aup_pkg::t_work                    i_work,
    output logic                              o_valid,
    input  logic                              i_ready,
    output aup_pkg::t_work                    o_work
);
    import aup_pkg::*;

    logic  r_valid;
    t_work r_work;
    t_work n_work;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_work  = r_work;

    // Restoring division: resolve the next quotient bits of every lane.
    always_comb begin
        logic [BIT_IDX_W-1:0] sh;
        logic [NUM_W-1:0]     dvs;
        n_work = i_work;
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            for (int s = 0; s < BITS_PER_STAGE; s++) begin
                sh  = BIT_IDX_W'(CHAN_W - 1 - int'(i_stage) * BITS_PER_STAGE - s);
                dvs = NUM_W'(i_work.alpha) << sh;
                if (n_work.lane[ch].rem >= dvs) begin
                    n_work.lane[ch].rem     = n_work.lane[ch].rem - dvs;
                    n_work.lane[ch].quo[sh] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

endmodule

[hw/rtl/aup_pack.sv]
module aup_pack (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  aup_pkg::t_work   i_work,
    output logic             o_valid,
    input  logic             i_ready,
    output aup_pkg::t_result o_result
);
    import aup_pkg::*;

    logic    r_valid;
    t_result r_result;
    t_result n_result;
    t_chan   fixed [NUM_CHAN];

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Zero alpha wins over saturation; saturation wins over the quotient.
    always_comb begin
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            priority if (i_work.zero) begin
                fixed[ch] = '0;
            end else if (i_work.sat[ch]) begin
                fixed[ch] = CHAN_MAX;
            end else begin
                fixed[ch] = i_work.lane[ch].quo;
            end
        end
        n_result.red   = fixed[LANE_RED];
        n_result.green = fixed[LANE_GREEN];
        n_result.blue  = fixed[LANE_BLUE];
        n_result.alpha = i_work.alpha;
        n_result.last  = i_work.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= n_result;
        end
    end

endmodule

[hw/rtl/alpha_unpremultiply_pixel.sv]
// Channel  Dir  Word contents
// -------  ---  ---------------------------------------------------------
// i_pix    in   argb_pixel (A 31:24, R 23:16, G 15:8, B 7:0), last_pixel
// o_pix    out  red_out, green_out, blue_out, alpha_out, last_out
//
// One word per clock sustained while o_pix is not stalled; six register stages lie
// between the accepting edge on i_pix and the word leaving on o_pix.
// The depth is set by the division: four stages of two restoring steps each,
// between a numerator stage in front and a saturate/pack register at the end.
// Synchronous active-low reset clears only the per-stage valid bits.
// A stall on o_pix fills the empty stages first, then backs i_pix.ready up;
// no word is dropped or repeated.
module alpha_unpremultiply_pixel (
    input  logic            i_clk,
    input  logic            i_rst_n,
    aup_in_if.sink          i_pix,
    aup_out_if.source       o_pix
);
    import aup_pkg::*;

    // Stage 0 is the numerator stage, stage k+1 the output of divider stage k.
    logic [NUM_DIV_STAGES:0] stg_valid;
    logic [NUM_DIV_STAGES:0] stg_ready;
    t_work                   stg_work [NUM_DIV_STAGES+1];
    t_result                 result;

    // Build c*255 + alpha/2 and the saturation flags.
    aup_prep u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_pix.valid),
        .o_ready      (i_pix.ready),
        .i_argb_pixel (i_pix.argb_pixel),
        .i_last_pixel (i_pix.last_pixel),
        .o_valid      (stg_valid[0]),
        .i_ready      (stg_ready[0]),
        .o_work       (stg_work[0])
    );

    // Advance the quotient bits, most significant first.
    for (genvar k = 0; k < NUM_DIV_STAGES; k++) begin : g_div
        aup_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (STAGE_IDX_W'(k)),
            .i_valid (stg_valid[k]),
            .o_ready (stg_ready[k]),
            .i_work  (stg_work[k]),
            .o_valid (stg_valid[k+1]),
            .i_ready (stg_ready[k+1]),
            .o_work  (stg_work[k+1])
        );
    end

    // Clamp, zero on transparent pixels, and hold the word for the sink.
    aup_pack u_pack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (stg_valid[NUM_DIV_STAGES]),
        .o_ready  (stg_ready[NUM_DIV_STAGES]),
        .i_work   (stg_work[NUM_DIV_STAGES]),
        .o_valid  (o_pix.valid),
        .i_ready  (o_pix.ready),
        .o_result (result)
    );

    assign o_pix.red_out   = result.red;
    assign o_pix.green_out = result.green;
    assign o_pix.blue_out  = result.blue;
    assign o_pix.alpha_out = result.alpha;
    assign o_pix.last_out  = result.last;

endmodule

[tb/tb_alpha_unpremultiply_pixel.sv]
`timescale 1ns / 100ps

module tb_alpha_unpremultiply_pixel;
    import aup_pkg::*;

    // Tail after the drain, long enough to catch strays from the pipeline.
    localparam int TAIL_CYCLES  = 12;
    // Generous bound on the whole run, far above the slowest correct one.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PERCENT = 24;

    logic i_clk;
    logic i_rst_n;

    aup_in_if  in_ch ();
    aup_out_if out_ch ();

    // Straight-alpha words still owed by the block, oldest first.
    t_result straight_pixels[$];
    int      mismatch_count = 0;
    int      cycle_count;
    // Set to run both sides at full rate, with no bubbles or stalls.
    logic    full_rate;

    alpha_unpremultiply_pixel DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (in_ch),
        .o_pix   (out_ch)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Divide one color channel by alpha with rounding; clamp invalid
    // premultiplied data (channel above alpha) at full scale.
    function automatic t_chan unpremul_chan(input t_chan c, input t_chan a);
        int unsigned q;
        if (a == '0) begin
            return '0;
        end
        q = (32'(c) * 32'(CHAN_MAX) + 32'(a >> 1)) / 32'(a);
        if (q > 32'(CHAN_MAX)) begin
            return CHAN_MAX;
        end
        return t_chan'(q);
    endfunction

    function automatic t_result unpremultiply(input logic [PIXEL_W-1:0] argb,
                                              input logic is_last);
        t_result res;
        t_chan   a;
        a           = argb[31:24];
        res.red     = unpremul_chan(argb[23:16], a);
        res.green   = unpremul_chan(argb[15:8], a);
        res.blue    = unpremul_chan(argb[7:0], a);
        res.alpha   = a;
        res.last    = is_last;
        return res;
    endfunction

    // Build a random ARGB word: mostly well-formed premultiplied data,
    // the rest zero alpha, alpha extremes and raw noise.
    function automatic logic [PIXEL_W-1:0] random_argb();
        int unsigned mode;
        int unsigned a;
        mode = $urandom_range(0, 99);
        if (mode < 65) begin
            a = $urandom_range(1, 255);
            return {8'(a), 8'($urandom_range(0, a)), 8'($urandom_range(0, a)),
                    8'($urandom_range(0, a))};
        end else if (mode < 75) begin
            return {8'h00, 24'($urandom)};
        end else if (mode < 85) begin
            case ($urandom_range(0, 3))
                0: a = 1;
                1: a = 2;
                2: a = 254;
                default: a = 255;
            endcase
            return {8'(a), 8'($urandom_range(0, a)), 8'($urandom_range(0, a)),
                    8'($urandom_range(0, a))};
        end
        return $urandom;
    endfunction

    // Offer one word on i_pix, with random bubbles in front of it, and hold
    // it until the block takes it. Record the expected result on acceptance.
    task automatic send_pixel(input logic [PIXEL_W-1:0] argb, input logic is_last);
        @(negedge i_clk);
        while (!full_rate && $urandom_range(0, 99) < IDLE_PERCENT) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid      = 1'b1;
        in_ch.argb_pixel = argb;
        in_ch.last_pixel = is_last;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        straight_pixels.push_back(unpremultiply(argb, is_last));
    endtask

    // Drop valid and hold off until every owed word has come out.
    task automatic wait_drained();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (straight_pixels.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic test_extremes();
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(32'hFF00_0000, 1'b0);
        send_pixel(32'h0101_0101, 1'b0);
        send_pixel(32'h0201_0101, 1'b0);
        send_pixel(32'h8040_4040, 1'b0);
        send_pixel(32'hFF12_3456, 1'b0);
        send_pixel(32'hAA55_AA55, 1'b0);
        send_pixel(32'h55AA_55AA, 1'b0);
        send_pixel(32'hFE7F_FE01, 1'b0);
    endtask

    // Zero alpha must blank all three colors, whatever they hold.
    task automatic test_zero_alpha();
        send_pixel(32'h00FF_FFFF, 1'b0);
        send_pixel(32'h0080_0001, 1'b1);
        send_pixel(32'h0001_FF80, 1'b0);
    endtask

    // Channels above alpha must clamp at full scale.
    task automatic test_channel_above_alpha();
        send_pixel(32'h01FF_FFFF, 1'b0);
        send_pixel(32'h10FF_0010, 1'b0);
        send_pixel(32'h7F80_FF7F, 1'b0);
        send_pixel(32'hFEFF_00FE, 1'b0);
    endtask

    task automatic test_last_marker();
        send_pixel(32'hFFFF_FFFF, 1'b1);
        send_pixel(32'h0000_0000, 1'b1);
        send_pixel(32'h8080_8080, 1'b1);
    endtask

    task automatic test_random_idle(input int count);
        for (int i = 0; i < count; i++) begin
            send_pixel(random_argb(), 1'($urandom_range(0, 1)));
        end
    endtask

    // Run a long burst with no bubbles on i_pix and no stalls on o_pix.
    task automatic test_random_full_rate(input int count);
        full_rate = 1'b1;
        test_random_idle(count);
        full_rate = 1'b0;
    endtask

    // Pause the sender until the pipeline is empty, then restart it.
    task automatic test_drain_restart();
        test_random_idle(40);
        wait_drained();
        test_random_idle(60);
    endtask

    // Randomly stall o_pix; hold ready high during the full-rate burst.
    always @(negedge i_clk) begin
        out_ch.ready = full_rate || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Compare every accepted output word against the oldest expectation.
    always @(posedge i_clk) begin
        t_result exp_px;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (straight_pixels.size() == 0) begin
                $error("unexpected output word: red %0h green %0h blue %0h alpha %0h",
                       out_ch.red_out, out_ch.green_out, out_ch.blue_out,
                       out_ch.alpha_out);
                mismatch_count++;
            end else begin
                exp_px = straight_pixels.pop_front();
                if (out_ch.red_out !== exp_px.red) begin
                    $error("red_out: expected %0h, got %0h", exp_px.red, out_ch.red_out);
                    mismatch_count++;
                end
                if (out_ch.green_out !== exp_px.green) begin
                    $error("green_out: expected %0h, got %0h", exp_px.green,
                           out_ch.green_out);
                    mismatch_count++;
                end
                if (out_ch.blue_out !== exp_px.blue) begin
                    $error("blue_out: expected %0h, got %0h", exp_px.blue,
                           out_ch.blue_out);
                    mismatch_count++;
                end
                if (out_ch.alpha_out !== exp_px.alpha) begin
                    $error("alpha_out: expected %0h, got %0h", exp_px.alpha,
                           out_ch.alpha_out);
                    mismatch_count++;
                end
                if (out_ch.last_out !== exp_px.last) begin
                    $error("last_out: expected %0b, got %0b", exp_px.last,
                           out_ch.last_out);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run if it hangs.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_alpha_unpremultiply_pixel: FAIL");
        $finish;
    end

    initial begin
        full_rate        = 1'b0;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.argb_pixel = '0;
        in_ch.last_pixel = 1'b0;

        // Hold reset, then release it on a falling edge.
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_extremes();
        test_zero_alpha();
        test_channel_above_alpha();
        test_last_marker();
        test_random_idle(600);
        test_random_full_rate(400);
        test_drain_restart();
        test_random_idle(100);

        // Drop valid, wait out every owed word, then watch for strays.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("tb_alpha_unpremultiply_pixel: PASS");
        end else begin
            $display("tb_alpha_unpremultiply_pixel: FAIL");
        end
        $finish;
    end

endmodule
